[sv/bmep_pkg.sv]
package bmep_pkg;

  // Field widths of one input octet and one framing result, plus internal accumulator and counter widths
  localparam int unsigned DataW  = 8;
  localparam int unsigned LenW   = 17;
  localparam int unsigned IdW    = 31;
  localparam int unsigned AccW   = 32;
  localparam int unsigned CountW = 3;

  // BER tag values
  localparam logic [DataW-1:0] SEQ_TAG    = 8'h30;
  localparam logic [DataW-1:0] INT_TAG    = 8'h02;
  localparam logic [DataW-1:0] UNBIND_TAG = 8'h42;

  // Low tag bits all set means a multi-octet tag
  localparam logic [4:0] TAG_NUM_MASK = 5'h1F;

  // Long-form length limits (count of length octets) and the ID value octet limit
  localparam logic [6:0] OUTER_LEN_OCTETS_LIMIT = 7'd3;
  localparam logic [6:0] INNER_LEN_OCTETS_MAX   = 7'd4;
  localparam logic [6:0] ID_VALUE_OCTETS_MAX    = 7'd4;

  // Outer header is tag plus one length octet before any long-form octets
  localparam logic [CountW-1:0] OUTER_HDR_BASE = 3'd2;

  // Register reset value
  localparam logic [LenW-1:0] MAX_MSG_RESET = 17'd1024;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             start_req;
  } octet_t;

  typedef struct packed {
    logic             status;
    logic [LenW-1:0]  message_octets;
    logic [IdW-1:0]   message_id;
    logic [DataW-1:0] operation_tag;
  } result_t;

endpackage

[sv/bmep_intf.sv]
interface bmep_in_if;
  import bmep_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

interface bmep_out_if;
  import bmep_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic [LenW-1:0]  message_octets;
  logic [IdW-1:0]   message_id;
  logic [DataW-1:0] operation_tag;

  modport source (output valid, output status, output message_octets, output message_id,
                  output operation_tag, input ready);
  modport sink (input valid, input status, input message_octets, input message_id,
                input operation_tag, output ready);
endinterface

[sv/ber_message_envelope_parser_top.sv]
// BER message envelope parser.
// octet_i carries one received octet per transaction (data_byte) and a
// start_req flag that restarts framing at that octet. result_o carries one
// transaction per framed message: status 0 with the total length, messageID
// and protocolOp tag, or status 1 with zero fields as soon as a malformed
// envelope is detected; after an error octets are dropped until start_req.
// cfg_we_i/cfg_wdata_i write the largest accepted message size (reset 1024);
// write it only while no octet is in flight.
// A result reaches result_o through the input register and then the result
// register after the octet that completes or breaks the envelope is accepted.
// Throughput: one octet per cycle while result_o is not stalled; the state
// update for one octet is a single pass of decode logic between those two
// registers. Reset clears both registers' valid flags and returns the parser
// to waiting for an outer SEQUENCE tag. When result_o stalls, the input
// register takes at most one more octet and then octet_i.ready stays low
// until the result register drains.
module ber_message_envelope_parser_top
  import bmep_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  bmep_in_if.sink         octet_i,
  bmep_out_if.source      result_o,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i
);

  logic    s1_valid;
  octet_t  s1_octet;
  logic    out_free;
  logic    go;
  logic    res_valid;
  result_t res;

  // Process the held octet whenever the result slot can take an outcome
  assign go = s1_valid && out_free;

  bmep_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .octet_i (octet_i),
    .take_i  (go),
    .valid_o (s1_valid),
    .octet_o (s1_octet)
  );

  bmep_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .go_i        (go),
    .octet_i     (s1_octet),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bmep_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (go && res_valid),
    .res_i    (res),
    .free_o   (out_free),
    .result_o (result_o)
  );

endmodule

[sv/bmep_in_stage.sv]
module bmep_in_stage
  import bmep_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bmep_in_if.sink    octet_i,
  input  logic       take_i,
  output logic       valid_o,
  output octet_t     octet_o
);

  logic   vld_q, vld_d;
  octet_t oct_q;

  // Accept when empty or when the held octet moves on this cycle
  assign octet_i.ready = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (take_i) begin
      vld_d = 1'b0;
    end
    if (octet_i.valid && octet_i.ready) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture payload on every accepted transaction
  always_ff @(posedge clk_i) begin
    if (octet_i.valid && octet_i.ready) begin
      oct_q.data_byte <= octet_i.data_byte;
      oct_q.start_req <= octet_i.start_req;
    end
  end

  assign valid_o = vld_q;
  assign octet_o = oct_q;

endmodule

[sv/bmep_parser.sv]
module bmep_parser
  import bmep_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  input  logic            go_i,
  input  octet_t          octet_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  typedef enum logic [3:0] {
    PH_TAG,
    PH_LEN0,
    PH_LENX,
    PH_IDTAG,
    PH_IDLEN0,
    PH_IDLENX,
    PH_IDVAL,
    PH_OPTAG,
    PH_OPLEN0,
    PH_OPLENX,
    PH_SKIP,
    PH_DROP
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   len_left_q, len_left_d;
  logic [AccW-1:0]     len_acc_q, len_acc_d;
  logic [LenW-1:0]     env_rem_q, env_rem_d;
  logic [CountW-1:0]   hdr_octets_q, hdr_octets_d;
  logic [IdW-1:0]      id_acc_q, id_acc_d;
  logic [CountW-1:0]   id_left_q, id_left_d;
  logic [DataW-1:0]    op_tag_q, op_tag_d;
  logic [LenW-1:0]     msg_total_q, msg_total_d;
  logic [LenW-1:0]     max_msg_q;

  logic [DataW-1:0]    b;
  logic [6:0]          nb;
  logic [LenW-1:0]     total;
  logic                drop, bad, ok;
  logic                fin_outer, start_id, op_short, enter_skip;

  assign b  = octet_i.data_byte;
  assign nb = b[6:0];

  // Hold the size limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q <= MAX_MSG_RESET;
    end else if (cfg_we_i) begin
      max_msg_q <= cfg_wdata_i;
    end
  end

  // Advance the framing state by one octet
  always_comb begin
    phase_d      = phase_q;
    len_left_d   = len_left_q;
    len_acc_d    = len_acc_q;
    env_rem_d    = env_rem_q;
    hdr_octets_d = hdr_octets_q;
    id_acc_d     = id_acc_q;
    id_left_d    = id_left_q;
    op_tag_d     = op_tag_q;
    msg_total_d  = msg_total_q;
    total        = '0;
    drop         = 1'b0;
    bad          = 1'b0;
    ok           = 1'b0;
    fin_outer    = 1'b0;
    start_id     = 1'b0;
    op_short     = 1'b0;
    enter_skip   = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (go_i) begin
      // Restart on a start marker, otherwise drop while in error
      if (octet_i.start_req) begin
        phase_d      = PH_TAG;
        len_left_d   = '0;
        len_acc_d    = '0;
        env_rem_d    = '0;
        hdr_octets_d = '0;
        id_acc_d     = '0;
        id_left_d    = '0;
        op_tag_d     = '0;
        msg_total_d  = '0;
      end else if (phase_q == PH_DROP) begin
        drop = 1'b1;
      end

      if (!drop) begin
        // Every octet inside the envelope uses up one remaining octet
        if (phase_d inside {[PH_IDTAG:PH_SKIP]}) begin
          if (env_rem_d == '0) begin
            bad = 1'b1;
          end else begin
            env_rem_d = env_rem_d - 1'b1;
          end
        end

        if (!bad) begin
          case (phase_d)
            PH_TAG: begin
              if (b != SEQ_TAG) begin
                bad = 1'b1;
              end else begin
                phase_d = PH_LEN0;
              end
            end
            PH_LEN0: begin
              if (b[7]) begin
                if (nb == '0 || nb >= OUTER_LEN_OCTETS_LIMIT) begin
                  bad = 1'b1;
                end else begin
                  len_left_d   = nb[CountW-1:0];
                  hdr_octets_d = OUTER_HDR_BASE + nb[CountW-1:0];
                  len_acc_d    = '0;
                  phase_d      = PH_LENX;
                end
              end else begin
                hdr_octets_d = OUTER_HDR_BASE;
                len_acc_d    = {{(AccW-DataW){1'b0}}, b};
                fin_outer    = 1'b1;
              end
            end
            PH_LENX: begin
              len_acc_d  = {16'd0, len_acc_d[7:0], b};
              len_left_d = len_left_d - 1'b1;
              if (len_left_d == '0) begin
                fin_outer = 1'b1;
              end
            end
            PH_IDTAG: begin
              if (b != INT_TAG || env_rem_d == '0) begin
                bad = 1'b1;
              end else begin
                phase_d = PH_IDLEN0;
              end
            end
            PH_IDLEN0: begin
              if (b[7]) begin
                if (nb == '0 || nb > INNER_LEN_OCTETS_MAX ||
                    {{(LenW-7){1'b0}}, nb} > env_rem_d) begin
                  bad = 1'b1;
                end else begin
                  len_left_d = nb[CountW-1:0];
                  len_acc_d  = '0;
                  phase_d    = PH_IDLENX;
                end
              end else begin
                len_acc_d = {{(AccW-DataW){1'b0}}, b};
                start_id  = 1'b1;
              end
            end
            PH_IDLENX: begin
              len_acc_d  = {len_acc_d[AccW-DataW-1:0], b};
              len_left_d = len_left_d - 1'b1;
              if (len_left_d == '0) begin
                start_id = 1'b1;
              end
            end
            PH_IDVAL: begin
              // First value octet must keep the ID non-negative
              if ({{(AccW-CountW){1'b0}}, id_left_d} == len_acc_d && b[7]) begin
                bad = 1'b1;
              end else begin
                id_acc_d  = {id_acc_d[IdW-DataW-1:0], b};
                id_left_d = id_left_d - 1'b1;
                if (id_left_d == '0) begin
                  if (env_rem_d == '0) begin
                    bad = 1'b1;
                  end else begin
                    phase_d = PH_OPTAG;
                  end
                end
              end
            end
            PH_OPTAG: begin
              op_tag_d = b;
              if (env_rem_d == '0) begin
                op_short = 1'b1;
              end else if (b[4:0] == TAG_NUM_MASK) begin
                bad = 1'b1;
              end else begin
                phase_d = PH_OPLEN0;
              end
            end
            PH_OPLEN0: begin
              if (b[7]) begin
                if (nb == '0 || nb > INNER_LEN_OCTETS_MAX) begin
                  bad = 1'b1;
                end else if ({{(LenW-7){1'b0}}, nb} > env_rem_d) begin
                  op_short = 1'b1;
                end else begin
                  len_left_d = nb[CountW-1:0];
                  len_acc_d  = '0;
                  phase_d    = PH_OPLENX;
                end
              end else if ({{(LenW-DataW){1'b0}}, b} > env_rem_d) begin
                op_short = 1'b1;
              end else begin
                enter_skip = 1'b1;
              end
            end
            PH_OPLENX: begin
              len_acc_d  = {len_acc_d[AccW-DataW-1:0], b};
              len_left_d = len_left_d - 1'b1;
              if (len_left_d == '0) begin
                if (len_acc_d > {{(AccW-LenW){1'b0}}, env_rem_d}) begin
                  op_short = 1'b1;
                end else begin
                  enter_skip = 1'b1;
                end
              end
            end
            PH_SKIP: begin
              if (env_rem_d == '0) begin
                ok = 1'b1;
              end
            end
            default: begin
              bad = 1'b1;
            end
          endcase
        end

        // Outer length known: check it against the limit
        if (fin_outer) begin
          total = {{(LenW-CountW){1'b0}}, hdr_octets_d} + {1'b0, len_acc_d[15:0]};
          if (len_acc_d == '0 || total > max_msg_q) begin
            bad = 1'b1;
          end else begin
            msg_total_d = total;
            env_rem_d   = len_acc_d[LenW-1:0];
            phase_d     = PH_IDTAG;
          end
        end

        // ID length known: it must be 1 to 4 octets and fit the envelope
        if (start_id) begin
          if (len_acc_d == '0 ||
              len_acc_d > {{(AccW-7){1'b0}}, ID_VALUE_OCTETS_MAX} ||
              len_acc_d > {{(AccW-LenW){1'b0}}, env_rem_d}) begin
            bad = 1'b1;
          end else begin
            id_left_d = len_acc_d[CountW-1:0];
            id_acc_d  = '0;
            phase_d   = PH_IDVAL;
          end
        end

        // Truncated operation header is only good for an unbind
        if (op_short) begin
          if (op_tag_d == UNBIND_TAG) begin
            enter_skip = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end

        if (enter_skip) begin
          phase_d = PH_SKIP;
          if (env_rem_d == '0) begin
            ok = 1'b1;
          end
        end

        // Report the frame and restart or drop
        if (bad) begin
          phase_d     = PH_DROP;
          res_valid_o = 1'b1;
          res_o       = '0;
          res_o.status = 1'b1;
        end else if (ok) begin
          res_valid_o          = 1'b1;
          res_o.status         = 1'b0;
          res_o.message_octets = msg_total_d;
          res_o.message_id     = id_acc_d;
          res_o.operation_tag  = op_tag_d;
          phase_d      = PH_TAG;
          len_left_d   = '0;
          len_acc_d    = '0;
          env_rem_d    = '0;
          hdr_octets_d = '0;
          id_acc_d     = '0;
          id_left_d    = '0;
          op_tag_d     = '0;
          msg_total_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TAG;
      len_left_q   <= '0;
      len_acc_q    <= '0;
      env_rem_q    <= '0;
      hdr_octets_q <= '0;
      id_acc_q     <= '0;
      id_left_q    <= '0;
      op_tag_q     <= '0;
      msg_total_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      len_left_q   <= len_left_d;
      len_acc_q    <= len_acc_d;
      env_rem_q    <= env_rem_d;
      hdr_octets_q <= hdr_octets_d;
      id_acc_q     <= id_acc_d;
      id_left_q    <= id_left_d;
      op_tag_q     <= op_tag_d;
      msg_total_q  <= msg_total_d;
    end
  end

endmodule

[sv/bmep_out_stage.sv]
module bmep_out_stage
  import bmep_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  result_t     res_i,
  output logic        free_o,
  bmep_out_if.source  result_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  // Slot is free when empty or drained this cycle
  assign free_o = !vld_q || result_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (result_o.ready) begin
      vld_d = 1'b0;
    end
    if (load_i) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid          = vld_q;
  assign result_o.status         = res_q.status;
  assign result_o.message_octets = res_q.message_octets;
  assign result_o.message_id     = res_q.message_id;
  assign result_o.operation_tag  = res_q.operation_tag;

endmodule
